### rtl/assert_macros.svh
// Assertion helpers included by the scheduler top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, muted while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication check: when the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dsos_pkg.sv
package dsos_pkg;

  // Sizing of the request store and the cylinder fields.
  localparam int unsigned MAX_REQUESTS = 16;
  localparam int unsigned CYL_W        = 12;
  localparam int unsigned TOT_W        = 13;
  localparam int unsigned CNT_CFG_W    = 13;
  localparam int unsigned IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 13;

  localparam logic [CNT_CFG_W-1:0] CYL_LIMIT       = CNT_CFG_W'(1 << CYL_W);
  localparam logic [CNT_CFG_W-1:0] CYL_COUNT_RESET = CNT_CFG_W'(500);
  localparam logic [TOT_W-1:0]     TOTAL_MAX       = {TOT_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT = 2'd2;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0] visit_cylinder;
    logic             is_request;
    logic [CYL_W-1:0] move_distance;
    logic [TOT_W-1:0] total_movement;
    logic             overflow;
    logic             last_result;
  } res_t;

  // Sequencer states: loading, insertion walk, start search, the two sweeps and the end stop.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_FIND,
    ST_ASC,
    ST_END,
    ST_DESC
  } state_e;

  // Operands and results of the shared compare and distance unit.
  typedef struct packed {
    logic [CYL_W-1:0] a;
    logic [CYL_W-1:0] b;
    logic [TOT_W-1:0] total;
  } alu_in_t;

  typedef struct packed {
    logic             gt;
    logic [CYL_W-1:0] diff;
    logic [TOT_W-1:0] sum;
  } alu_out_t;

endpackage

### rtl/dsos_alu.sv
module dsos_alu (
  input  dsos_pkg::alu_in_t  alu_i,
  output dsos_pkg::alu_out_t alu_o
);
  import dsos_pkg::*;

  logic [TOT_W:0] sum_wide;

  // Magnitude compare and absolute distance between the two cylinders.
  assign alu_o.gt   = (alu_i.a > alu_i.b);
  assign alu_o.diff = (alu_i.a >= alu_i.b) ? (alu_i.a - alu_i.b) : (alu_i.b - alu_i.a);

  // Running total with saturation at the top of the field.
  assign sum_wide  = {1'b0, alu_i.total} + (TOT_W + 1)'(alu_o.diff);
  assign alu_o.sum = sum_wide[TOT_W] ? TOTAL_MAX : sum_wide[TOT_W-1:0];

endmodule

### rtl/dsos_store.sv
module dsos_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [dsos_pkg::IDX_W-1:0]  waddr_i,
  input  logic [dsos_pkg::CYL_W-1:0]  wdata_i,
  input  logic [dsos_pkg::IDX_W-1:0]  raddr_i,
  output logic [dsos_pkg::CYL_W-1:0]  rdata_o
);
  import dsos_pkg::*;

  // Sorted request entries; contents are undefined until written.
  logic [CYL_W-1:0] mem_q [MAX_REQUESTS];
  logic [CYL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a write to the address being read passes its new data through.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/disk_seek_order_scheduler_top.sv
// SCAN/LOOK seek-order scheduler. Requests are taken one per transfer and inserted into a
// sorted store of up to MAX_REQUESTS entries; a request accepted while the store is full is
// dropped and sets overflow on every result of its batch. A request that fits is placed by
// an insertion walk through the single compare unit: larger entries move up one place at a
// time, then the request is written into the gap. The request flagged last_request then
// starts scheduling: entries below the start head are skipped to find the sweep start, and
// one result per cycle (at most MAX_REQUESTS + 1 in all) goes to the output register while
// it is free. The block stalls its input for the whole of that work. Results come in order:
// requests at or above the head ascending, the end-of-disk stop in SCAN mode, then the lower
// requests descending. Configuration is written through a plain write port and may be
// changed only while no batch is being scheduled.
module disk_seek_order_scheduler_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dsos_pkg::req_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dsos_pkg::res_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dsos_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dsos_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import dsos_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic                 scan_mode_q;
  logic [CYL_W-1:0]     start_head_q;
  logic [CNT_CFG_W-1:0] cyl_count_q;

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 dropped_q, dropped_d;
  logic [CYL_W-1:0]     head_q, head_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic                 out_valid_q, out_valid_d;

  logic [CYL_W-1:0]     cyl_q, cyl_d;
  logic                 last_q, last_d;
  logic [IDX_W-1:0]     ins_q, ins_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  res_t                 out_q, out_d;

  logic [CYL_W-1:0]     last_cyl;
  logic [CYL_W-1:0]     head_init;
  logic [CYL_W-1:0]     in_cyl;
  logic                 in_fire;
  logic                 out_free;
  logic                 emit_fire;
  logic                 emit_last;
  logic [CYL_W-1:0]     visit_cyl;

  logic                 st_we;
  logic [IDX_W-1:0]     st_waddr;
  logic [CYL_W-1:0]     st_wdata;
  logic [IDX_W-1:0]     st_raddr;
  logic [CYL_W-1:0]     st_rdata;

  alu_in_t              alu_in;
  alu_out_t             alu_out;

  dsos_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  dsos_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  // Last cylinder from the configured count, with zero and oversize counts clamped.
  always_comb begin
    if (cyl_count_q == '0) begin
      last_cyl = '0;
    end else if (cyl_count_q > CYL_LIMIT) begin
      last_cyl = {CYL_W{1'b1}};
    end else begin
      last_cyl = CYL_W'(cyl_count_q - 1'b1);
    end
  end

  assign head_init = (start_head_q > last_cyl) ? last_cyl : start_head_q;
  assign in_cyl    = (in_data_i.request_cylinder > last_cyl) ? last_cyl
                                                             : in_data_i.request_cylinder;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer: next state, store access, shared unit operands and result formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dropped_d   = dropped_q;
    head_d      = head_q;
    total_d     = total_q;
    cyl_d       = cyl_q;
    last_d      = last_q;
    ins_d       = ins_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    st_we       = 1'b0;
    st_waddr    = ins_q;
    st_wdata    = cyl_q;

    emit_fire   = 1'b0;
    emit_last   = 1'b0;
    visit_cyl   = st_rdata;

    alu_in.a     = st_rdata;
    alu_in.b     = cyl_q;
    alu_in.total = total_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cyl_d  = in_cyl;
          last_d = in_data_i.last_request;
          if (count_q == CNT_W'(MAX_REQUESTS)) begin
            dropped_d = 1'b1;
            if (in_data_i.last_request) begin
              head_d  = head_init;
              total_d = '0;
              pos_d   = '0;
              state_d = ST_FIND;
            end
          end else begin
            ins_d   = count_q[IDX_W-1:0];
            state_d = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        // Shift larger entries up one place until the new request fits.
        if ((ins_q != '0) && alu_out.gt) begin
          st_we    = 1'b1;
          st_wdata = st_rdata;
          ins_d    = ins_q - 1'b1;
        end else begin
          st_we   = 1'b1;
          count_d = count_q + 1'b1;
          if (last_q) begin
            head_d  = head_init;
            total_d = '0;
            pos_d   = '0;
            state_d = ST_FIND;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_FIND: begin
        // Skip entries below the head; the first one at or above it starts the upward sweep.
        alu_in.a = head_q;
        alu_in.b = st_rdata;
        if ((pos_q < count_q) && alu_out.gt) begin
          pos_d = pos_q + 1'b1;
        end else if (pos_q < count_q) begin
          idx_d   = pos_q;
          state_d = ST_ASC;
        end else if (scan_mode_q) begin
          state_d = ST_END;
        end else begin
          idx_d   = pos_q;
          state_d = ST_DESC;
        end
      end

      ST_ASC: begin
        emit_last = (idx_q == count_q - 1'b1) && !scan_mode_q && (pos_q == '0);
        if (out_free) begin
          emit_fire = 1'b1;
          idx_d     = idx_q + 1'b1;
          if (idx_q == count_q - 1'b1) begin
            if (scan_mode_q) begin
              state_d = ST_END;
            end else if (pos_q != '0) begin
              idx_d   = pos_q;
              state_d = ST_DESC;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_END: begin
        // End-of-disk turnaround stop, reported as a non-request result.
        visit_cyl = last_cyl;
        emit_last = (pos_q == '0);
        if (out_free) begin
          emit_fire = 1'b1;
          if (pos_q != '0) begin
            idx_d   = pos_q;
            state_d = ST_DESC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_DESC: begin
        emit_last = (idx_q == CNT_W'(1));
        if (out_free) begin
          emit_fire = 1'b1;
          idx_d     = idx_q - 1'b1;
          if (idx_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load one result into the output register and move the head.
    if ((state_q == ST_ASC) || (state_q == ST_END) || (state_q == ST_DESC)) begin
      alu_in.a = visit_cyl;
      alu_in.b = head_q;
    end
    if (emit_fire) begin
      out_d.visit_cylinder = visit_cyl;
      out_d.is_request     = (state_q != ST_END);
      out_d.move_distance  = alu_out.diff;
      out_d.total_movement = alu_out.sum;
      out_d.overflow       = dropped_q;
      out_d.last_result    = emit_last;
      out_valid_d          = 1'b1;
      head_d               = visit_cyl;
      total_d              = alu_out.sum;
      if (emit_last) begin
        count_d   = '0;
        dropped_d = 1'b0;
      end
    end

    // Store address for the entry that the next state works on.
    case (state_d)
      ST_INSERT: st_raddr = ins_d - 1'b1;
      ST_FIND:   st_raddr = pos_d[IDX_W-1:0];
      ST_ASC:    st_raddr = idx_d[IDX_W-1:0];
      ST_DESC:   st_raddr = idx_d[IDX_W-1:0] - 1'b1;
      default:   st_raddr = '0;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      dropped_q    <= 1'b0;
      head_q       <= '0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      scan_mode_q  <= 1'b1;
      start_head_q <= '0;
      cyl_count_q  <= CYL_COUNT_RESET;
    end else begin
      count_q     <= count_d;
      dropped_q   <= dropped_d;
      head_q      <= head_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCAN_MODE:      scan_mode_q  <= cfg_wdata_i[0];
          CFG_START_HEAD:     start_head_q <= cfg_wdata_i[CYL_W-1:0];
          CFG_CYLINDER_COUNT: cyl_count_q  <= cfg_wdata_i[CNT_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    cyl_q  <= cyl_d;
    last_q <= last_d;
    ins_q  <= ins_d;
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Design checks.
  `ASSERT_CLK(a_count_bound, count_q <= CNT_W'(MAX_REQUESTS),
    "request count exceeds store capacity")
  `ASSERT_CLK(a_drop_when_full, $rose(dropped_q) |-> (count_q == CNT_W'(MAX_REQUESTS)),
    "request dropped while store had room")
  `ASSERT_CLK(a_find_nonempty, (state_q == ST_FIND) |-> (count_q != '0),
    "scheduling started on an empty store")
  `ASSERT_NEXT(a_batch_cleanup, emit_fire && emit_last,
    (state_q == ST_IDLE) && (count_q == '0) && !dropped_q,
    "batch state not cleared after final result")

endmodule

### test/seek_order_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and configuration ports of the seek-order scheduler. It keeps
// its own sorted copy of the pending requests and computes the visit sequence of each batch.
module seek_order_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  dsos_pkg::req_t                  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  dsos_pkg::res_t                  out_data_i,
  input  logic                            cfg_we_i,
  input  logic [dsos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsos_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     outstanding_o
);
  import dsos_pkg::*;

  // Shadow of the scheduler state and its configuration.
  logic [CYL_W-1:0]     sorted_cyl [MAX_REQUESTS];
  int unsigned          held;
  logic [CYL_W-1:0]     head_pos;
  int unsigned          travelled;
  logic                 dropped;
  logic                 scan_on;
  logic [CYL_W-1:0]     start_cyl;
  logic [CNT_CFG_W-1:0] cyl_count;

  // Visits computed but not yet seen on the result port, oldest first.
  res_t        expected_visits [$];
  int unsigned errors = 0;

  assign mismatches_o = errors;

  // Highest cylinder on the disk, with out-of-range counts pulled into range.
  function automatic int unsigned top_cylinder();
    int unsigned c;
    c = cyl_count;
    if (c == 0) c = 1;
    if (c > CYL_LIMIT) c = CYL_LIMIT;
    return c - 1;
  endfunction

  // Moves the head to a cylinder and returns the visit that the move produces.
  function automatic res_t move_head(int unsigned cyl, logic is_req);
    res_t        v;
    int unsigned span;
    span = (cyl >= head_pos) ? cyl - head_pos : head_pos - cyl;
    travelled = (travelled + span > TOTAL_MAX) ? TOTAL_MAX : travelled + span;
    head_pos = CYL_W'(cyl);
    v.visit_cylinder = CYL_W'(cyl);
    v.is_request     = is_req;
    v.move_distance  = CYL_W'(span);
    v.total_movement = TOT_W'(travelled);
    v.overflow       = dropped;
    v.last_result    = 1'b0;
    return v;
  endfunction

  // Inserts one request in order; the last request of a batch schedules the whole sweep.
  task automatic accept_request(req_t r);
    int unsigned lc, cyl, slot, pos;
    res_t        batch [$];
    lc = top_cylinder();
    cyl = r.request_cylinder;
    if (cyl > lc) cyl = lc;
    if (held < MAX_REQUESTS) begin
      slot = held;
      while (slot > 0 && sorted_cyl[slot-1] > cyl) begin
        sorted_cyl[slot] = sorted_cyl[slot-1];
        slot--;
      end
      sorted_cyl[slot] = CYL_W'(cyl);
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (r.last_request) begin
      head_pos = (start_cyl > lc) ? CYL_W'(lc) : start_cyl;
      travelled = 0;
      pos = 0;
      while (pos < held && sorted_cyl[pos] < head_pos) pos++;
      // Upward sweep, the end-of-disk stop in SCAN mode, then the downward sweep.
      for (int unsigned i = pos; i < held; i++) batch.push_back(move_head(sorted_cyl[i], 1'b1));
      if (scan_on) batch.push_back(move_head(lc, 1'b0));
      for (int unsigned i = pos; i > 0; i--) batch.push_back(move_head(sorted_cyl[i-1], 1'b1));
      if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
      expected_visits = {expected_visits, batch};
      held = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Track configuration writes, request transfers and result transfers at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      held      = 0;
      head_pos  = '0;
      travelled = 0;
      dropped   = 1'b0;
      scan_on   = 1'b1;
      start_cyl = '0;
      cyl_count = CYL_COUNT_RESET;
      expected_visits.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCAN_MODE:      scan_on   = cfg_wdata_i[0];
          CFG_START_HEAD:     start_cyl = cfg_wdata_i[CYL_W-1:0];
          CFG_CYLINDER_COUNT: cyl_count = cfg_wdata_i[CNT_CFG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) accept_request(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_visits.size() == 0) begin
          errors++;
          $display("%0t: result expected none, got cylinder %0d", $time,
                   out_data_i.visit_cylinder);
        end else begin
          want = expected_visits.pop_front();
          check_field("visit_cylinder", want.visit_cylinder, out_data_i.visit_cylinder);
          check_field("is_request", want.is_request, out_data_i.is_request);
          check_field("move_distance", want.move_distance, out_data_i.move_distance);
          check_field("total_movement", want.total_movement, out_data_i.total_movement);
          check_field("overflow", want.overflow, out_data_i.overflow);
          check_field("last_result", want.last_result, out_data_i.last_result);
        end
      end
      outstanding_o <= expected_visits.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dsos_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 185;
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_REQUESTS + 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  req_valid;
  logic                  req_stall;
  req_t                  req_data;
  logic                  visit_valid;
  logic                  visit_stall = 1'b0;
  res_t                  visit_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           outstanding;

  // Configuration as last written, used to aim requests at the interesting cylinders.
  logic [CYL_W-1:0]      cur_head  = '0;
  logic [CNT_CFG_W-1:0]  cur_count = CYL_COUNT_RESET;
  int unsigned           burst_left = 0;

  stall_mode_e           stall_mode = STALL_NONE;
  int unsigned           mode_left = 0;
  int unsigned           cycles = 0;

  disk_seek_order_scheduler_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_data_i   (req_data),
    .out_valid_o (visit_valid),
    .out_stall_i (visit_stall),
    .out_data_o  (visit_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  seek_order_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_i    (req_stall),
    .in_data_i     (req_data),
    .out_valid_i   (visit_valid),
    .out_stall_i   (visit_stall),
    .out_data_i    (visit_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls in modes that are redrawn at random whenever the current one runs out.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  visit_stall <= 1'b0;
      STALL_LIGHT: visit_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: visit_stall <= ($urandom_range(0, 7) != 0);
      default:     visit_stall <= ~visit_stall;
    endcase
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("disk_seek_order_scheduler_top regression: fail");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it transfers.
  task automatic send_req(logic [CYL_W-1:0] cyl, logic last);
    req_valid <= 1'b1;
    req_data  <= '{request_cylinder: cyl, last_request: last};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Requests go out in bursts; a new burst may start after an idle gap.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Holds off until every visit has arrived and the scheduler has gone quiet.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic scan, logic [CYL_W-1:0] hd, logic [CNT_CFG_W-1:0] cnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SCAN_MODE;
    cfg_wdata <= CFG_DATA_W'(scan);
    @(posedge clk);
    cfg_idx   <= CFG_START_HEAD;
    cfg_wdata <= CFG_DATA_W'(hd);
    @(posedge clk);
    cfg_idx   <= CFG_CYLINDER_COUNT;
    cfg_wdata <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_head  = hd;
    cur_count = cnt;
  endtask

  // Favors cylinder zero, the top of the field, the last cylinder, one past it and the head.
  function automatic logic [CYL_W-1:0] pick_cylinder();
    int unsigned lc;
    if (cur_count == 0) lc = 0;
    else if (cur_count > CYL_LIMIT) lc = CYL_LIMIT - 1;
    else lc = cur_count - 1;
    case ($urandom_range(0, 10))
      0:       return '0;
      1:       return '1;
      2:       return CYL_W'(lc);
      3:       return CYL_W'(lc + 1);
      4:       return cur_head;
      5, 6, 7: return CYL_W'($urandom_range(0, 4095));
      default: return CYL_W'($urandom_range(0, lc));
    endcase
  endfunction

  task automatic random_config();
    logic [CNT_CFG_W-1:0] cnt;
    logic [CYL_W-1:0]     hd;
    case ($urandom_range(0, 9))
      0:       cnt = '0;
      1:       cnt = CNT_CFG_W'(1);
      2:       cnt = '1;
      3:       cnt = CYL_LIMIT;
      4:       cnt = CNT_CFG_W'(CYL_LIMIT + 1);
      5:       cnt = CNT_CFG_W'($urandom_range(2, 64));
      default: cnt = CNT_CFG_W'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 5))
      0:       hd = '0;
      1:       hd = '1;
      default: hd = CYL_W'($urandom);
    endcase
    write_config(1'($urandom_range(0, 1)), hd, cnt);
  endtask

  initial begin
    int unsigned sent, n;
    logic [CYL_W-1:0] cyl;
    rst_n     = 1'b0;
    req_valid = 1'b0;
    req_data  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_SCAN_MODE;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: an out-of-range request clamped to the last cylinder, SCAN with
    // nothing below the head.
    pace();
    send_req('1, 1'b0);
    pace();
    send_req(12'd250, 1'b0);
    pace();
    send_req('0, 1'b1);

    // LOOK over the full disk with more requests than the store holds, one equal to the head.
    write_config(1'b0, 12'd2048, CYL_LIMIT);
    for (int unsigned i = 0; i < MAX_REQUESTS + 2; i++) begin
      if (i == 0) cyl = 12'd2048;
      else if (i == 1) cyl = '1;
      else cyl = CYL_W'(((i - 2) * 1237) % 4096);
      pace();
      send_req(cyl, i == MAX_REQUESTS + 1);
    end

    // SCAN with the head already on the last cylinder; an oversized count acts as the maximum.
    write_config(1'b1, '1, '1);
    pace();
    send_req('1, 1'b1);

    // A zero count leaves a single cylinder, so head and request both clamp to it.
    write_config(1'b0, 12'd100, '0);
    pace();
    send_req('1, 1'b1);

    // Random batches under changing settings, mostly small, now and then overfilling the store.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) random_config();
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
        1, 2:    n = $urandom_range(9, MAX_REQUESTS);
        default: n = $urandom_range(1, 8);
      endcase
      for (int unsigned j = 0; j < n; j++) begin
        pace();
        send_req(pick_cylinder(), j == n - 1);
      end
      sent += n;
    end

    drain();
    if (mismatches == 0) begin
      $display("disk_seek_order_scheduler_top regression: pass");
    end else begin
      $display("disk_seek_order_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/dsos_pkg.sv
rtl/dsos_alu.sv
rtl/dsos_store.sv
rtl/disk_seek_order_scheduler_top.sv
test/seek_order_checker.sv
test/testbench.sv
